FILE: rtl/core/lphm_pkg.sv
// ---------------------------------------------------------------------------
// lphm_pkg: shared types and constants
// Table geometry, register indexes, status codes, payload and control structs.
// ---------------------------------------------------------------------------
package lphm_pkg;

    localparam int SLOTS   = 512;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int LIMIT_W = 10;
    localparam int SHIFT_W = 4;
    localparam int COUNT_W = 10;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SHIFT   = 8'd1;

    localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST = 10'd16;
    localparam logic [SHIFT_W-1:0] KEY_SHIFT_RST   = 4'd4;

    localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic             kind;   // 0 lookup, 1 insert
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VAL_W-1:0]   found_value;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;     // latch request
        logic              rd_home;  // read home slot, arm probe counter
        logic              advance;  // read next slot, count one probe
        logic              ins_wr;   // claim current slot
        logic              clr_wr;   // clearing pass write
        logic              finish;   // register result
        logic [STAT_W-1:0] status;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_insert;
        logic key_zero;
        logic limit_zero;
        logic key_match;
        logic slot_empty;
        logic last_probe;
        logic clear_last;
    } ctl_sts_t;

endpackage

FILE: rtl/core/lphm_ram.sv
// ---------------------------------------------------------------------------
// lphm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lphm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/lphm_datapath.sv
// ---------------------------------------------------------------------------
// lphm_datapath: key/value stores, probe pointer and result register
// Holds config registers, occupied count and the clearing pass index.
// ---------------------------------------------------------------------------
module lphm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [lphm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lphm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  lphm_pkg::req_t                    req,
    input  lphm_pkg::ctl_cmd_t                cmd,
    output lphm_pkg::ctl_sts_t                sts,
    output lphm_pkg::rsp_t                    rsp
);
    import lphm_pkg::*;

    logic [LIMIT_W-1:0] probe_limit_reg;
    logic [SHIFT_W-1:0] key_shift_reg;
    req_t               req_reg;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [LIMIT_W-1:0] left_reg;
    logic [SLOT_W-1:0]  clr_idx_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    rsp_t               rsp_reg;

    logic [KEY_W-1:0]   shifted;
    logic [SLOT_W-1:0]  home_slot;
    logic [LIMIT_W-1:0] probe_n;
    logic [SLOT_W-1:0]  rd_addr;
    logic [KEY_W-1:0]   key_rdata;
    logic [VAL_W-1:0]   val_rdata;
    logic               key_we;
    logic [SLOT_W-1:0]  key_waddr;
    logic [KEY_W-1:0]   key_wdata;

    // home slot: shifted key masked to the table size
    assign shifted   = req_reg.key >> key_shift_reg;
    assign home_slot = shifted[SLOT_W-1:0];
    assign probe_n   = (probe_limit_reg > LIMIT_W'(SLOTS)) ? LIMIT_W'(SLOTS) : probe_limit_reg;
    assign slot_next = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign rd_addr   = cmd.rd_home ? home_slot : slot_next;

    assign key_we    = cmd.clr_wr | cmd.ins_wr;
    assign key_waddr = cmd.clr_wr ? clr_idx_reg : slot_reg;
    assign key_wdata = cmd.clr_wr ? '0 : req_reg.key;

    assign count_next = (cmd.ins_wr && count_reg != '1) ? count_reg + 1'b1 : count_reg;

    lphm_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (key_wdata),
        .rd_addr (rd_addr),
        .rd_data (key_rdata)
    );

    lphm_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
        .clk     (clk),
        .wr_en   (cmd.ins_wr),
        .wr_addr (slot_reg),
        .wr_data (req_reg.value),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_limit_reg <= PROBE_LIMIT_RST;
            key_shift_reg   <= KEY_SHIFT_RST;
            clr_idx_reg     <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_PROBE_LIMIT)
            begin
                probe_limit_reg <= cfg_data[LIMIT_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_KEY_SHIFT)
            begin
                key_shift_reg <= cfg_data[SHIFT_W-1:0];
            end
            if (cmd.clr_wr)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.rd_home)
        begin
            slot_reg <= home_slot;
            left_reg <= probe_n;
        end
        else if (cmd.advance)
        begin
            slot_reg <= slot_next;
            left_reg <= left_reg - 1'b1;
        end
        if (cmd.finish)
        begin
            rsp_reg.status      <= cmd.status;
            rsp_reg.found_value <= (cmd.status == ST_HIT) ? val_rdata : '0;
            rsp_reg.entry_count <= count_next;
        end
    end

    assign sts.is_insert  = req_reg.kind;
    assign sts.key_zero   = (req_reg.key == '0);
    assign sts.limit_zero = (probe_n == '0);
    assign sts.key_match  = (key_rdata == req_reg.key);
    assign sts.slot_empty = (key_rdata == '0);
    assign sts.last_probe = (left_reg == LIMIT_W'(1));
    assign sts.clear_last = (clr_idx_reg == SLOT_W'(SLOTS - 1));

    assign rsp = rsp_reg;

endmodule

FILE: rtl/core/lphm_ctrl.sv
// ---------------------------------------------------------------------------
// lphm_ctrl: operation sequencer
// Clearing pass, request load, one probe per cycle, result strobe.
// ---------------------------------------------------------------------------
module lphm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  lphm_pkg::ctl_sts_t   sts,
    output lphm_pkg::ctl_cmd_t   cmd
);
    import lphm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_PROBE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (sts.key_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = sts.is_insert ? ST_PRESENT : ST_MISS;
                    state_next = S_IDLE;
                end
                else if (sts.limit_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = sts.is_insert ? ST_FULL : ST_MISS;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_home = 1'b1;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.key_match)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = sts.is_insert ? ST_PRESENT : ST_HIT;
                    state_next = S_IDLE;
                end
                else if (sts.slot_empty)
                begin
                    cmd.finish = 1'b1;
                    cmd.ins_wr = sts.is_insert;
                    cmd.status = sts.is_insert ? ST_INSERTED : ST_MISS;
                    state_next = S_IDLE;
                end
                else if (sts.last_probe)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = sts.is_insert ? ST_FULL : ST_MISS;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef NO_ASSERTIONS
    a_done_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_ISSUE || $past(state_reg) == S_PROBE))
        else $error("result strobe without an operation in flight");

    a_ins_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |-> (state_reg == S_PROBE && sts.slot_empty && !sts.key_match))
        else $error("slot claimed that is not empty");

    a_start_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_ISSUE))
        else $error("accepted transaction did not start");

    a_no_clear_mix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> (!cmd.ins_wr && !cmd.finish))
        else $error("clearing pass overlaps an operation");
`endif

endmodule

FILE: rtl/core/linear_probe_hash_map_unit.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_map_unit: insert-only open-addressing hash map
// 512-slot key/value table with linear probing, controller plus datapath.
// ---------------------------------------------------------------------------
// Sequence: S_ISSUE reads the home slot, S_PROBE checks k slots, and done is
//   registered from the finish; 1 <= k <= min(probe_limit, 512); k = 0 for key
//   zero or probe limit zero.
// Throughput: a new transaction is accepted only while busy is low (S_IDLE);
//   one probe per cycle, set by the single read port of the key RAM.
// Reset: async active low; a clearing pass zeroes all 512 key RAM slots with
//   busy high. Config writes are taken at any time. done cannot be stalled.
// ---------------------------------------------------------------------------
module linear_probe_hash_map_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // transaction in
    input  logic                              start,
    output logic                              busy,
    input  lphm_pkg::req_t                    req,
    // result out, one cycle per transaction
    output logic                              done,
    output lphm_pkg::rsp_t                    rsp,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lphm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lphm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lphm_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // Registers are plain flops: always ready.
    assign cfg_ready = 1'b1;

    // Sequencer: clear pass, then load / home read / probe loop / finish.
    lphm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Stores, probe pointer, counters and the result register.
    lphm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule
